FILE: hw/rtl/wsta_pkg.sv
// wsta_pkg: shared constants, codes and controller/datapath structs
// for the windowed slope trend alarm; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wsta_pkg;

   localparam int DEF_MAX_WINDOW = 32;
   localparam int DEF_FRAC_BITS  = 16;
   localparam int DATA_W         = 32;
   localparam int WIN_W          = 6;
   localparam int SLOPE_W        = 48;
   localparam int CSR_IDX_W      = 1;
   localparam int WIN_RESET      = 30;
   localparam int THR_RESET_INT  = 1024;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_WINDOW_LEN = 1'd0;
   localparam csr_idx_type CSR_ALARM_THR  = 1'd1;

   typedef logic [1:0] mul_op_type;
   localparam mul_op_type OP_N_SXY  = 2'd0;
   localparam mul_op_type OP_SX_SY  = 2'd1;
   localparam mul_op_type OP_N_SXX  = 2'd2;
   localparam mul_op_type OP_SX_SX  = 2'd3;

   typedef struct packed {
      logic       accept;
      logic       walk_init;
      logic       rd_issue;
      logic       load_xy;
      logic       mac_xy;
      logic       mac_xx;
      logic       mul_load;
      mul_op_type mul_op;
      logic       mul_step;
      logic       div_load;
      logic       div_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic n_small;
      logic last_entry;
      logic acc_zero;
   } status_type;

endpackage
`default_nettype wire

FILE: hw/rtl/wsta_ram.sv
// wsta_ram: generic single-write, single-read RAM with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module wsta_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/wsta_ctrl.sv
// wsta_ctrl: sequencer for sample walk, serial multiplies and division
// depends on wsta_pkg
`timescale 1ns / 1ps
`default_nettype none
module wsta_ctrl #(
   parameter int MAX_WINDOW = wsta_pkg::DEF_MAX_WINDOW,
   parameter int FRAC_BITS  = wsta_pkg::DEF_FRAC_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire wsta_pkg::status_type   status,
   output      wsta_pkg::cmd_type      cmd
);
   import wsta_pkg::*;

   localparam int LW    = $clog2(MAX_WINDOW + 1);
   localparam int SXW   = DATA_W + LW;
   localparam int MW    = 2 * DATA_W + 2 * LW;
   localparam int NW    = MW + FRAC_BITS;
   localparam int CNT_W = $clog2(NW);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CHK  = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_XY   = 4'd3;
   localparam logic [3:0] S_MXY  = 4'd4;
   localparam logic [3:0] S_MXX  = 4'd5;
   localparam logic [3:0] S_MLD  = 4'd6;
   localparam logic [3:0] S_MST  = 4'd7;
   localparam logic [3:0] S_DLD  = 4'd8;
   localparam logic [3:0] S_DST  = 4'd9;
   localparam logic [3:0] S_FIN  = 4'd10;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   mul_op_type       op_ff, op_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.mul_op = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHK;
            end
         end
         S_CHK: begin
            cmd.walk_init = 1'b1;
            state_in = status.n_small ? S_FIN : S_RD;
         end
         S_RD: begin
            cmd.rd_issue = 1'b1;
            state_in = S_XY;
         end
         S_XY: begin
            cmd.load_xy = 1'b1;
            state_in = S_MXY;
         end
         S_MXY: begin
            cmd.mac_xy = 1'b1;
            state_in = S_MXX;
         end
         S_MXX: begin
            cmd.mac_xx = 1'b1;
            if (status.last_entry) begin
               op_in    = OP_N_SXY;
               state_in = S_MLD;
            end else begin
               state_in = S_RD;
            end
         end
         S_MLD: begin
            cmd.mul_load = 1'b1;
            cnt_in   = '0;
            state_in = S_MST;
         end
         S_MST: begin
            cmd.mul_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SXW - 1)) begin
               if (op_ff == OP_SX_SX) begin
                  state_in = S_DLD;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = S_MLD;
               end
            end
         end
         S_DLD: begin
            cmd.div_load = 1'b1;
            cnt_in   = '0;
            state_in = status.acc_zero ? S_FIN : S_DST;
         end
         S_DST: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NW - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         op_ff        <= OP_N_SXY;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         op_ff        <= op_in;
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/wsta_dp.sv
// wsta_dp: sample ring, window sums, serial multiplier, restoring divider
// and result register; depends on wsta_pkg and wsta_ram
`timescale 1ns / 1ps
`default_nettype none
module wsta_dp #(
   parameter int MAX_WINDOW = wsta_pkg::DEF_MAX_WINDOW,
   parameter int FRAC_BITS  = wsta_pkg::DEF_FRAC_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [wsta_pkg::DATA_W-1:0]          req_sample_time_ms,
   input  wire logic [wsta_pkg::DATA_W-1:0]          req_sample_bytes,
   input  wire logic                                 csr_wr_en,
   input  wire wsta_pkg::csr_idx_type                csr_index,
   input  wire logic [wsta_pkg::SLOPE_W-1:0]         csr_wdata,
   input  wire wsta_pkg::cmd_type                    cmd,
   output      wsta_pkg::status_type                 status,
   output      logic signed [wsta_pkg::SLOPE_W-1:0]  rsp_slope_q16,
   output      logic                                 rsp_slope_valid,
   output      logic                                 rsp_alarm
);
   import wsta_pkg::*;

   localparam int AW   = $clog2(MAX_WINDOW);
   localparam int LW   = $clog2(MAX_WINDOW + 1);
   localparam int EW   = (LW > WIN_W) ? LW : WIN_W;
   localparam int OW   = AW + 1;
   localparam int SXW  = DATA_W + LW;
   localparam int PW   = 2 * DATA_W + LW;
   localparam int MW   = 2 * DATA_W + 2 * LW;
   localparam int NW   = MW + FRAC_BITS;
   localparam logic [SLOPE_W-1:0] THR_RESET = SLOPE_W'(64'(THR_RESET_INT) << FRAC_BITS);
   localparam logic [NW-1:0] Q_MAX_POS = NW'({1'b0, {(SLOPE_W-1){1'b1}}});
   localparam logic [NW-1:0] Q_MAX_NEG = NW'({1'b1, {(SLOPE_W-1){1'b0}}});

   logic [WIN_W-1:0]          win_ff;
   logic signed [SLOPE_W-1:0] thr_ff;
   logic [AW-1:0]             head_ff, ptr_ff;
   logic [LW-1:0]             fill_ff, k_ff;
   logic [DATA_W-1:0]         t0_ff, x_ff, y_ff;
   logic [SXW-1:0]            sx_ff, sy_ff, mp_ff;
   logic [PW-1:0]             sxy_ff, sxx_ff;
   logic [MW-1:0]             mc_ff, den_ff, rem_ff;
   logic signed [MW:0]        acc_ff, num_ff;
   logic                      sub_ff;
   logic [NW-1:0]             dvd_ff, quo_ff;

   // window clamp and fill update
   logic [EW-1:0]   win_ext;
   logic [LW-1:0]   win_eff;
   logic [LW:0]     fill_inc;
   logic [LW-1:0]   fill_in;
   logic [AW-1:0]   head_in, ptr_in;
   logic [OW:0]     old_sum;
   logic [AW-1:0]   oldest;

   always_comb begin
      win_ext = EW'(win_ff);
      if (win_ext == '0) begin
         win_eff = LW'(1);
      end else if (win_ext > EW'(MAX_WINDOW)) begin
         win_eff = LW'(MAX_WINDOW);
      end else begin
         win_eff = LW'(win_ext);
      end
      fill_inc = {1'b0, fill_ff} + 1'b1;
      fill_in  = (fill_inc > {1'b0, win_eff}) ? win_eff : LW'(fill_inc);
      head_in  = (head_ff == AW'(MAX_WINDOW - 1)) ? '0 : head_ff + 1'b1;
      ptr_in   = (ptr_ff == AW'(MAX_WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
      old_sum  = (OW+1)'(head_ff) + (OW+1)'(MAX_WINDOW) - (OW+1)'(fill_ff);
      if (old_sum >= (OW+1)'(MAX_WINDOW)) begin
         oldest = AW'(old_sum - (OW+1)'(MAX_WINDOW));
      end else begin
         oldest = AW'(old_sum);
      end
   end

   logic [2*DATA_W-1:0] rdata;

   wsta_ram #(.WIDTH(2 * DATA_W), .DEPTH(MAX_WINDOW)) u_ring (
      .clock (clock),
      .we    (cmd.accept),
      .waddr (head_ff),
      .wdata ({req_sample_time_ms, req_sample_bytes}),
      .re    (cmd.rd_issue),
      .raddr (ptr_ff),
      .rdata (rdata)
   );

   // shared 32x32 product for the sums
   logic [2*DATA_W-1:0] prod;
   assign prod = x_ff * (cmd.mac_xx ? x_ff : y_ff);

   // multiplier operand select
   logic [MW-1:0]  mul_a;
   logic [SXW-1:0] mul_b;
   always_comb begin
      case (cmd.mul_op)
         OP_N_SXY: begin
            mul_a = MW'(sxy_ff);
            mul_b = SXW'(fill_ff);
         end
         OP_SX_SY: begin
            mul_a = MW'(sx_ff);
            mul_b = sy_ff;
         end
         OP_N_SXX: begin
            mul_a = MW'(sxx_ff);
            mul_b = SXW'(fill_ff);
         end
         default: begin
            mul_a = MW'(sx_ff);
            mul_b = sx_ff;
         end
      endcase
   end

   logic signed [MW:0] term;
   assign term = mp_ff[0] ? $signed({1'b0, mc_ff}) : '0;

   logic [MW-1:0] num_mag;
   assign num_mag = num_ff[MW] ? MW'(-num_ff) : MW'(num_ff);

   logic [MW:0] trial;
   logic        qbit;
   assign trial = {rem_ff, dvd_ff[NW-1]};
   assign qbit  = (trial >= {1'b0, den_ff});

   // final saturation
   logic signed [SLOPE_W-1:0] slope;
   always_comb begin
      if (den_ff == '0) begin
         slope = '0;
      end else if (num_ff[MW]) begin
         slope = (quo_ff > Q_MAX_NEG) ? $signed(Q_MAX_NEG[SLOPE_W-1:0])
                                      : -$signed(quo_ff[SLOPE_W-1:0]);
      end else begin
         slope = (quo_ff > Q_MAX_POS) ? $signed(Q_MAX_POS[SLOPE_W-1:0])
                                      : $signed(quo_ff[SLOPE_W-1:0]);
      end
   end

   assign status.n_small    = (fill_ff < LW'(3));
   assign status.last_entry = (k_ff == fill_ff - 1'b1);
   assign status.acc_zero   = (acc_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= WIN_W'(WIN_RESET);
         thr_ff  <= $signed(THR_RESET);
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_WINDOW_LEN: win_ff <= csr_wdata[WIN_W-1:0];
               CSR_ALARM_THR:  thr_ff <= $signed(csr_wdata);
               default: ;
            endcase
         end
         if (cmd.accept) begin
            head_ff <= head_in;
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         ptr_ff <= oldest;
         k_ff   <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxy_ff <= '0;
         sxx_ff <= '0;
         den_ff <= '0;
      end
      if (cmd.rd_issue) begin
         ptr_ff <= ptr_in;
      end
      if (cmd.load_xy) begin
         y_ff <= rdata[DATA_W-1:0];
         if (k_ff == '0) begin
            t0_ff <= rdata[2*DATA_W-1:DATA_W];
            x_ff  <= '0;
         end else begin
            x_ff <= rdata[2*DATA_W-1:DATA_W] - t0_ff;
         end
      end
      if (cmd.mac_xy) begin
         sxy_ff <= sxy_ff + PW'(prod);
         sx_ff  <= sx_ff + SXW'(x_ff);
         sy_ff  <= sy_ff + SXW'(y_ff);
      end
      if (cmd.mac_xx) begin
         sxx_ff <= sxx_ff + PW'(prod);
         k_ff   <= k_ff + 1'b1;
      end
      if (cmd.mul_load) begin
         mc_ff  <= mul_a;
         mp_ff  <= mul_b;
         sub_ff <= cmd.mul_op[0];
         if (!cmd.mul_op[0]) begin
            acc_ff <= '0;
         end
         if (cmd.mul_op == OP_N_SXX) begin
            num_ff <= acc_ff;
         end
      end
      if (cmd.mul_step) begin
         acc_ff <= sub_ff ? acc_ff - term : acc_ff + term;
         mc_ff  <= mc_ff << 1;
         mp_ff  <= mp_ff >> 1;
      end
      if (cmd.div_load) begin
         den_ff <= acc_ff[MW-1:0];
         dvd_ff <= NW'(num_mag) << FRAC_BITS;
         rem_ff <= '0;
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= qbit ? MW'(trial - {1'b0, den_ff}) : MW'(trial);
         quo_ff <= {quo_ff[NW-2:0], qbit};
         dvd_ff <= dvd_ff << 1;
      end
      if (cmd.out_load) begin
         rsp_slope_q16   <= slope;
         rsp_slope_valid <= (den_ff != '0);
         rsp_alarm       <= (slope >= thr_ff);
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/windowed_slope_trend_alarm.sv
// windowed_slope_trend_alarm: top level, sliding-window least-squares slope
// each input walks the ring per held entry (read, load, xy and xx accumulate), then runs
// four bit-serial multiplies and the restoring divider before rsp_valid; below three
// samples the walk is skipped, and on a zero denominator the divider is skipped;
// one sample at a time, next input accepted in the cycle after result load
// synchronous active-high reset clears ring pointer, fill count, state and rsp_valid
`timescale 1ns / 1ps
`default_nettype none
module windowed_slope_trend_alarm #(
   parameter int MAX_WINDOW = wsta_pkg::DEF_MAX_WINDOW,
   parameter int FRAC_BITS  = wsta_pkg::DEF_FRAC_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic [wsta_pkg::DATA_W-1:0]          req_sample_time_ms,
   input  wire logic [wsta_pkg::DATA_W-1:0]          req_sample_bytes,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic signed [wsta_pkg::SLOPE_W-1:0]  rsp_slope_q16,
   output      logic                                 rsp_slope_valid,
   output      logic                                 rsp_alarm,
   input  wire logic                                 csr_wr_en,
   input  wire wsta_pkg::csr_idx_type                csr_index,
   input  wire logic [wsta_pkg::SLOPE_W-1:0]         csr_wdata
);
   import wsta_pkg::*;

   cmd_type    cmd;
   status_type status;

   wsta_ctrl #(.MAX_WINDOW(MAX_WINDOW), .FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wsta_dp #(.MAX_WINDOW(MAX_WINDOW), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_sample_time_ms (req_sample_time_ms),
      .req_sample_bytes   (req_sample_bytes),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .status             (status),
      .rsp_slope_q16      (rsp_slope_q16),
      .rsp_slope_valid    (rsp_slope_valid),
      .rsp_alarm          (rsp_alarm)
   );

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while a sample is in progress");

   a_invalid_slope_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_slope_valid) |-> (rsp_slope_q16 == '0))
      else $error("nonzero slope flagged invalid");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before transfer");

endmodule
`default_nettype wire

FILE: bench/tb_windowed_slope_trend_alarm.sv
// testbench for windowed_slope_trend_alarm: sliding-window slope fit and alarm,
// checked transfer by transfer against an in-bench predictor; depends on wsta_pkg
`timescale 1ns / 1ps
module tb_windowed_slope_trend_alarm;
   import wsta_pkg::*;

   localparam int RING = 32;
   localparam int FRAC = 16;
   localparam int EXP_DEPTH = 16;
   localparam longint unsigned LIMIT = 10000000;

   typedef struct packed {
      logic signed [SLOPE_W-1:0] slope;
      logic                      ok;
      logic                      alarm;
   } fit_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [DATA_W-1:0] req_sample_time_ms = '0;
   logic [DATA_W-1:0] req_sample_bytes = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [SLOPE_W-1:0] rsp_slope_q16;
   logic rsp_slope_valid;
   logic rsp_alarm;
   logic csr_wr_en = 0;
   csr_idx_type csr_index = CSR_WINDOW_LEN;
   logic [SLOPE_W-1:0] csr_wdata = '0;

   windowed_slope_trend_alarm dut (.*);

   // predictor state
   logic [31:0] t_hist [RING];
   logic [31:0] b_hist [RING];
   int unsigned head_q, held_q;
   logic [5:0] win_q;
   logic signed [SLOPE_W-1:0] thr_q;

   // expected results in transfer order
   fit_type exp_buf [EXP_DEPTH];
   int unsigned exp_wr, exp_rd;
   int unsigned mismatches;
   longint unsigned cycles;
   bit rsp_noise;

   initial forever #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("windowed_slope_trend_alarm test failed");
         $finish;
      end
   end

   function automatic fit_type predict_fit(logic [31:0] tm, logic [31:0] by);
      int unsigned w, n, oldest, idx;
      logic [31:0] t0;
      logic [63:0] x, sx, sy;
      logic [127:0] sxy, sxx, num, den, q;
      logic neg;
      fit_type r;
      w = (win_q == 0) ? 1 : (win_q > RING ? RING : win_q);
      t_hist[head_q] = tm;
      b_hist[head_q] = by;
      head_q = (head_q + 1) % RING;
      held_q = held_q + 1;
      if (held_q > w) held_q = w;
      n = held_q;
      r.slope = '0;
      r.ok = 0;
      if (n >= 3) begin
         oldest = (head_q + RING - n) % RING;
         t0 = t_hist[oldest];
         sx = 0; sy = 0; sxy = 0; sxx = 0;
         for (int k = 0; k < n; k++) begin
            idx = (oldest + k) % RING;
            x = {32'd0, t_hist[idx] - t0};
            sx += x;
            sy += {32'd0, b_hist[idx]};
            sxy += 128'(x) * 128'(b_hist[idx]);
            sxx += 128'(x) * 128'(x);
         end
         num = sxy * 128'(n) - 128'(sx) * 128'(sy);
         den = sxx * 128'(n) - 128'(sx) * 128'(sx);
         if (den != 0) begin
            neg = num[127];
            if (neg) num = -num;
            q = (num << FRAC) / den;
            r.ok = 1;
            if (neg) r.slope = (q > (128'd1 << 47)) ? {1'b1, 47'd0} : -q[47:0];
            else r.slope = (q > {81'd0, {47{1'b1}}}) ? {1'b0, {47{1'b1}}} : q[47:0];
         end
      end
      r.alarm = (r.slope >= thr_q);
      return r;
   endfunction

   task automatic pause_random();
      int g;
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
      repeat (g) @(posedge clock);
   endtask

   task automatic send_sample(logic [31:0] tm, logic [31:0] by);
      @(posedge clock);
      if ($urandom_range(0, 3) != 0) pause_random();
      req_valid <= 1;
      req_sample_time_ms <= tm;
      req_sample_bytes <= by;
      do @(posedge clock); while (!req_ready);
      exp_buf[exp_wr % EXP_DEPTH] = predict_fit(tm, by);
      exp_wr = exp_wr + 1;
      req_valid <= 0;
   endtask

   task automatic drain();
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type i, logic [SLOPE_W-1:0] v);
      csr_wr_en <= 1;
      csr_index <= i;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      if (i == CSR_WINDOW_LEN) win_q = v[5:0];
      else thr_q = v;
      @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_noise) rsp_ready <= ($urandom_range(0, 9) == 0) ? 0 : ($urandom_range(0, 2) != 0);
         else rsp_ready <= 1;
         if (rsp_valid && rsp_ready) begin
            if (exp_wr == exp_rd) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transfer slope=%0d", rsp_slope_q16);
            end else begin
               fit_type e;
               e = exp_buf[exp_rd % EXP_DEPTH];
               exp_rd = exp_rd + 1;
               if (e.slope !== rsp_slope_q16 || e.ok !== rsp_slope_valid ||
                   e.alarm !== rsp_alarm) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp slope=%0d ok=%0b alarm=%0b got %0d %0b %0b",
                              e.slope, e.ok, e.alarm, rsp_slope_q16, rsp_slope_valid,
                              rsp_alarm);
               end
            end
         end
      end
   end

   task automatic test_short_windows();
      send_sample(32'd0, 32'd0);
      send_sample(32'd10, 32'd100);
      send_sample(32'd20, 32'd200);
      send_sample(32'd20, 32'hFFFF_FFFF);
      drain();
      write_reg(CSR_WINDOW_LEN, 48'd0);
      send_sample(32'd5, 32'd5);
      send_sample(32'd6, 32'd6);
      drain();
      write_reg(CSR_WINDOW_LEN, 48'd3);
      // all times equal gives a zero denominator
      repeat (4) send_sample(32'hFFFF_FFFF, $urandom);
      drain();
   endtask

   task automatic test_extremes();
      write_reg(CSR_WINDOW_LEN, 48'd63);
      write_reg(CSR_ALARM_THR, {1'b1, 47'd0});
      send_sample(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_sample(32'hFFFF_FFFF, 32'd0);
      send_sample(32'd0, 32'hFFFF_FFFF);
      send_sample(32'd1, 32'd0);
      drain();
      write_reg(CSR_ALARM_THR, {1'b0, {47{1'b1}}});
      send_sample(32'd2, 32'hFFFF_FFFF);
      send_sample(32'd3, 32'hFFFF_FFFF);
      send_sample(32'h8000_0000, 32'h5555_5555);
      send_sample(32'hAAAA_AAAA, 32'hAAAA_AAAA);
      drain();
      // shrink to three, then grow
      write_reg(CSR_WINDOW_LEN, 48'd3);
      write_reg(CSR_ALARM_THR, 48'd0);
      send_sample(32'd100, 32'd7);
      drain();
      write_reg(CSR_WINDOW_LEN, 48'd32);
      send_sample(32'd101, 32'd9);
      send_sample(32'd102, 32'd11);
      drain();
   endtask

   task automatic test_random_trends();
      logic [31:0] tm, by;
      for (int ph = 0; ph < 10; ph++) begin
         write_reg(CSR_WINDOW_LEN, 48'($urandom_range(0, 63)));
         case (ph % 4)
            0: write_reg(CSR_ALARM_THR, 48'(1024) << FRAC);
            1: write_reg(CSR_ALARM_THR, 48'({$urandom, $urandom}));
            2: write_reg(CSR_ALARM_THR, -(48'($urandom_range(0, 4096)) << FRAC));
            default: write_reg(CSR_ALARM_THR, 48'($urandom_range(0, 200000)));
         endcase
         rsp_noise = (ph % 3 != 2);
         tm = $urandom;
         by = $urandom;
         for (int i = 0; i < 150; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               tm = $urandom;
               by = $urandom;
            end else begin
               tm = tm + $urandom_range(0, (ph % 2) ? 3 : 5000);
               by = by + $urandom_range(0, 200000) - 100000;
            end
            send_sample(tm, by);
         end
         drain();
      end
   endtask

   initial begin
      mismatches = 0;
      cycles = 0;
      rsp_noise = 1;
      exp_wr = 0;
      exp_rd = 0;
      head_q = 0;
      held_q = 0;
      win_q = 6'(WIN_RESET);
      thr_q = 48'(THR_RESET_INT) << FRAC;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_short_windows();
      test_extremes();
      test_random_trends();
      if (mismatches == 0) $display("windowed_slope_trend_alarm test passed");
      else $display("windowed_slope_trend_alarm test failed");
      $finish;
   end
endmodule

FILE: sim.f
hw/rtl/wsta_pkg.sv
hw/rtl/wsta_ram.sv
hw/rtl/wsta_ctrl.sv
hw/rtl/wsta_dp.sv
hw/rtl/windowed_slope_trend_alarm.sv
bench/tb_windowed_slope_trend_alarm.sv
